>>> src/depsq_pkg.sv
`default_nettype none

package depsq_pkg;

    localparam int TOTAL_W  = 48;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic OP_INSERT = 1'b0;

    // which end of a node interval is being worked on
    typedef enum logic {
        DIR_MIN,
        DIR_MAX
    } t_dir;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_NODE,
        S_INS_PAR,
        S_INS_FIN,
        S_RND_ROOT,
        S_RND_SUM,
        S_DEL_START,
        S_DEL_LAST,
        S_SFT_ROOT,
        S_SFT_NODE,
        S_SFT_C1,
        S_SFT_C2,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> src/double_ended_pop_spread_queue_top.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: value; tuser: op
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: largest..occupancy; tuser: status
//
// Values live in an interval heap: one memory word per node holds a {hi, lo} pair.
// Insert: one node read per heap level on the way up.
// Round: it deletes the minimum, then the maximum, each a sift down that reads two
// children per level through the single read port of the node memory.
// Reset clears the state, the output valid, the count and the total; the node memory needs no clearing.
// One item is in work at a time; a finished result waits in the output register.
`default_nettype none

module double_ended_pop_spread_queue_top import depsq_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 20,
    localparam int CW        = $clog2(CAPACITY + 1),
    localparam int IN_DW     = ((VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_DW    = ((3 * VALUE_BITS + TOTAL_W + CW + 7) / 8) * 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [IN_DW-1:0]    s_axis_tdata,  // value
    input  wire logic                s_axis_tuser,  // op
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [OUT_DW-1:0]        m_axis_tdata,  // largest, smallest, spread,
                                                    // running_total, occupancy
    output logic [STATUS_W-1:0]      m_axis_tuser   // status
);

    localparam int VB    = VALUE_BITS;
    localparam int NBW   = 2 * VALUE_BITS;
    localparam int NODES = (CAPACITY + 1) / 2;
    localparam int AW    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int XW    = CW + 1;

    function automatic logic [NBW-1:0] fill_hole(input logic [NBW-1:0] cur, input t_dir dir,
                                                 input logic sing, input logic [VB-1:0] v);
        logic [NBW-1:0] res;
        if (sing) begin
            res = {v, v};
        end else if (dir == DIR_MIN) begin
            res = {cur[NBW-1:VB], v};
        end else begin
            res = {v, cur[VB-1:0]};
        end
        return res;
    endfunction

    logic [NBW-1:0]      mem [NODES];
    logic [NBW-1:0]      r_mem_q;
    logic [NBW-1:0]      r_fwd_data;
    logic                r_fwd_hit;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [VB-1:0]       r_val, n_val;
    logic [NBW-1:0]      r_cur, n_cur;
    logic [NBW-1:0]      r_c1, n_c1;
    logic [AW-1:0]       r_idx, n_idx;
    t_dir                r_dir, n_dir;
    t_dir                r_phase, n_phase;
    logic                r_sing, n_sing;
    logic [VB-1:0]       r_big, n_big;
    logic [VB-1:0]       r_small, n_small;
    logic [VB-1:0]       r_spread, n_spread;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_out_valid, n_out_valid;
    logic [OUT_DW-1:0]   r_out_data, n_out_data;
    logic [STATUS_W-1:0] r_out_user, n_out_user;

    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [NBW-1:0]      wr_data;

    logic [NBW-1:0]      rd_data;
    logic [VB-1:0]       rd_lo, rd_hi;
    logic [XW-1:0]       idx_x, cnt_x, nc_x, last_x, c1_x, c2_x;
    logic [CW-1:0]       half_cnt;
    logic [AW-1:0]       par_idx, gpar_idx;
    logic                has_c1, has_c2;
    logic [NBW-1:0]      node_in;
    logic [VB-1:0]       in_lo, in_hi;
    logic                sing_at, swap_en;
    logic [NBW-1:0]      ent_cur;
    logic [VB-1:0]       ent_y;
    logic                pick_c2;
    logic [NBW-1:0]      ch_data;
    logic [XW-1:0]       ch_idx;
    logic [VB-1:0]       ch_key;
    logic                ch_stop;
    t_dir                ins_dir;
    logic                move_min, move_max;
    logic [TOTAL_W:0]    sum_x;

    assign rd_data  = r_fwd_hit ? r_fwd_data : r_mem_q;
    assign rd_lo    = rd_data[VB-1:0];
    assign rd_hi    = rd_data[NBW-1:VB];

    assign idx_x    = XW'(r_idx);
    assign cnt_x    = XW'(r_cnt);
    assign nc_x     = (cnt_x + XW'(1)) >> 1;
    assign last_x   = (cnt_x - XW'(1)) >> 1;
    assign c1_x     = {idx_x[XW-2:0], 1'b1};
    assign c2_x     = c1_x + XW'(1);
    assign has_c1   = c1_x < nc_x;
    assign has_c2   = c2_x < nc_x;
    assign half_cnt = r_cnt >> 1;
    assign par_idx  = (r_idx - AW'(1)) >> 1;
    assign gpar_idx = (par_idx - AW'(1)) >> 1;

    // entering a node during a sift: swap the carried value with the far end if needed
    assign node_in  = (r_state == S_SFT_ROOT) ? rd_data : r_cur;
    assign in_lo    = node_in[VB-1:0];
    assign in_hi    = node_in[NBW-1:VB];
    assign sing_at  = r_cnt[0] && (idx_x == last_x);
    assign swap_en  = !sing_at && ((r_phase == DIR_MIN) ? (r_val > in_hi) : (r_val < in_lo));
    assign ent_cur  = !swap_en ? node_in :
                      (r_phase == DIR_MIN) ? {r_val, in_lo} : {in_hi, r_val};
    assign ent_y    = !swap_en ? r_val : (r_phase == DIR_MIN) ? in_hi : in_lo;

    assign pick_c2  = (r_phase == DIR_MIN) ? (rd_lo < r_c1[VB-1:0]) : (rd_hi > r_c1[NBW-1:VB]);
    assign ch_data  = (r_state == S_SFT_C2 && !pick_c2) ? r_c1 : rd_data;
    assign ch_idx   = (r_state == S_SFT_C2 && pick_c2) ? c2_x : c1_x;
    assign ch_key   = (r_phase == DIR_MIN) ? ch_data[VB-1:0] : ch_data[NBW-1:VB];
    assign ch_stop  = (r_phase == DIR_MIN) ? (r_val <= ch_key) : (r_val >= ch_key);

    assign ins_dir  = (r_val >= rd_lo) ? DIR_MAX : DIR_MIN;
    assign move_min = (r_sing || r_dir == DIR_MIN) && (r_val < rd_lo);
    assign move_max = (r_sing || r_dir == DIR_MAX) && (r_val > rd_hi);

    assign sum_x    = {1'b0, r_total} + (TOTAL_W + 1)'(r_spread);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_val       = r_val;
        n_cur       = r_cur;
        n_c1        = r_c1;
        n_idx       = r_idx;
        n_dir       = r_dir;
        n_phase     = r_phase;
        n_sing      = r_sing;
        n_big       = r_big;
        n_small     = r_small;
        n_spread    = r_spread;
        n_status    = r_status;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = '0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_val    = s_axis_tdata[VB-1:0];
                    n_big    = '0;
                    n_small  = '0;
                    n_spread = '0;
                    n_status = STATUS_OK;
                    if (s_axis_tuser == OP_INSERT) begin
                        if (r_cnt == CW'(CAPACITY)) begin
                            n_status = STATUS_FULL;
                            n_state  = S_DONE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = half_cnt[AW-1:0];
                            n_idx   = half_cnt[AW-1:0];
                            n_cnt   = r_cnt + CW'(1);
                            n_sing  = !r_cnt[0];
                            n_state = S_INS_NODE;
                        end
                    end else if (r_cnt == '0) begin
                        n_status = STATUS_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = S_RND_ROOT;
                    end
                end
            end

            S_INS_NODE: begin
                n_cur = {rd_lo, rd_lo};
                n_dir = ins_dir;
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    wr_data = fill_hole({rd_lo, rd_lo}, ins_dir, r_sing, r_val);
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = par_idx;
                    n_state = S_INS_PAR;
                end
            end

            S_INS_PAR: begin
                wr_en = 1'b1;
                if (move_min || move_max) begin
                    // pull the parent's end down and climb one level
                    n_dir   = move_min ? DIR_MIN : DIR_MAX;
                    wr_data = fill_hole(r_cur, n_dir, r_sing, move_min ? rd_lo : rd_hi);
                    n_cur   = rd_data;
                    n_sing  = 1'b0;
                    n_idx   = par_idx;
                    if (par_idx == '0) begin
                        n_state = S_INS_FIN;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = gpar_idx;
                    end
                end else begin
                    wr_data = fill_hole(r_cur, r_dir, r_sing, r_val);
                    n_state = S_DONE;
                end
            end

            S_INS_FIN: begin
                wr_en   = 1'b1;
                wr_data = fill_hole(r_cur, r_dir, r_sing, r_val);
                n_state = S_DONE;
            end

            S_RND_ROOT: begin
                n_big    = rd_hi;
                n_small  = rd_lo;
                n_spread = rd_hi - rd_lo;
                n_state  = S_RND_SUM;
            end

            S_RND_SUM: begin
                n_total = sum_x[TOTAL_W] ? '1 : sum_x[TOTAL_W-1:0];
                if (r_cnt <= CW'(2)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_phase = DIR_MIN;
                    n_state = S_DEL_START;
                end
            end

            S_DEL_START: begin
                rd_en   = 1'b1;
                rd_addr = last_x[AW-1:0];
                n_state = S_DEL_LAST;
            end

            S_DEL_LAST: begin
                // take one value off the last node as the refill for the root
                wr_addr = last_x[AW-1:0];
                if (r_cnt[0]) begin
                    n_val = rd_lo;
                end else if (r_phase == DIR_MIN) begin
                    n_val   = rd_hi;
                    wr_en   = 1'b1;
                    wr_data = {rd_lo, rd_lo};
                end else begin
                    n_val   = rd_lo;
                    wr_en   = 1'b1;
                    wr_data = {rd_hi, rd_hi};
                end
                n_cnt   = r_cnt - CW'(1);
                n_idx   = '0;
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = S_SFT_ROOT;
            end

            S_SFT_ROOT, S_SFT_NODE: begin
                n_cur  = ent_cur;
                n_val  = ent_y;
                n_sing = sing_at;
                if (!has_c1) begin
                    wr_en   = 1'b1;
                    wr_data = fill_hole(ent_cur, r_phase, sing_at, ent_y);
                    if (r_phase == DIR_MIN) begin
                        n_phase = DIR_MAX;
                        n_state = S_DEL_START;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = c1_x[AW-1:0];
                    n_state = S_SFT_C1;
                end
            end

            S_SFT_C1, S_SFT_C2: begin
                n_c1 = rd_data;
                if (r_state == S_SFT_C1 && has_c2) begin
                    rd_en   = 1'b1;
                    rd_addr = c2_x[AW-1:0];
                    n_state = S_SFT_C2;
                end else begin
                    wr_en = 1'b1;
                    if (ch_stop) begin
                        wr_data = fill_hole(r_cur, r_phase, r_sing, r_val);
                        if (r_phase == DIR_MIN) begin
                            n_phase = DIR_MAX;
                            n_state = S_DEL_START;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        // move the child's end up and descend
                        wr_data = fill_hole(r_cur, r_phase, r_sing, ch_key);
                        n_cur   = ch_data;
                        n_idx   = ch_idx[AW-1:0];
                        n_state = S_SFT_NODE;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_DW'({r_cnt, r_total, r_spread, r_small, r_big});
                    n_out_user  = r_status;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q    <= mem[rd_addr];
            r_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            // forward a write that lands on the entry being read in the same cycle
            if (rd_en) begin
                r_fwd_hit <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_cur      <= n_cur;
        r_c1       <= n_c1;
        r_idx      <= n_idx;
        r_dir      <= n_dir;
        r_phase    <= n_phase;
        r_sing     <= n_sing;
        r_big      <= n_big;
        r_small    <= n_small;
        r_spread   <= n_spread;
        r_status   <= n_status;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

endmodule

`default_nettype wire

>>> src/depsq_checker.sv
`default_nettype none

module depsq_checker import depsq_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 20,
    localparam int CW        = $clog2(CAPACITY + 1),
    localparam int IN_DW     = ((VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_DW    = ((3 * VALUE_BITS + TOTAL_W + CW + 7) / 8) * 8
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic [IN_DW-1:0]    s_axis_tdata,
    input wire logic                s_axis_tuser,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [OUT_DW-1:0]   m_axis_tdata,
    input wire logic [STATUS_W-1:0] m_axis_tuser
);

    localparam int VB = VALUE_BITS;

    logic [VB-1:0] big, small_v, spread;
    logic [CW-1:0] occ;

    assign big     = m_axis_tdata[VB-1:0];
    assign small_v = m_axis_tdata[2*VB-1:VB];
    assign spread  = m_axis_tdata[3*VB-1:2*VB];
    assign occ     = m_axis_tdata[3*VB+TOTAL_W+CW-1:3*VB+TOTAL_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_EMPTY |->
            occ == '0 && big == '0 && small_v == '0 && spread == '0)
        else $error("empty round reported values");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_FULL |-> occ == CW'(CAPACITY))
        else $error("full insert with store not full");

    a_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_OK |->
            big >= small_v && spread == big - small_v)
        else $error("extremes out of order or spread wrong");

    // input side is only observed
    logic unused_in;
    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ s_axis_tuser ^ (^s_axis_tdata);

endmodule

bind double_ended_pop_spread_queue_top depsq_checker #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
) u_depsq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
